/* hdl/rtsd_pkg.sv */
// Shared types and constants for the run-length transparent sprite decoder.
// No dependencies.
package rtsd_pkg;

  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 240;

  localparam int ADDR_W  = 17;
  localparam int COLOR_W = 16;
  localparam int CFG_W   = 9;
  localparam int POS_W   = 12;

  localparam logic [8:0] CLIP_RIGHT_RST  = 9'd320;
  localparam logic [7:0] CLIP_BOTTOM_RST = 8'd240;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_PALETTE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_CLIP_LEFT   = 2'd0,
    CFG_CLIP_TOP    = 2'd1,
    CFG_CLIP_RIGHT  = 2'd2,
    CFG_CLIP_BOTTOM = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [8:0] clip_left;
    logic [7:0] clip_top;
    logic [8:0] clip_right;
    logic [7:0] clip_bottom;
  } cfg_t;

  typedef struct packed {
    logic              wr;
    logic              done;
    logic [ADDR_W-1:0] addr;
  } pix_t;

endpackage

/* hdl/rle_transparent_sprite_decode.sv */
// Top level of the run-length transparent sprite decoder: clip registers,
// walker, palette and result pipeline. Uses rtsd_pkg and the rtsd_* modules.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   kind, origin_*, sprite_*, clip_enable,
//                                             data_byte, entry_index, entry_color
//   out      output     out_valid / out_stall pixel_address, pixel_color,
//                                             write_pixel, sprite_end
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// One item per cycle while in_stall is low. A data beat passes through the
// palette read register and the stage register beside it, then the output register.
// Start and palette beats give no result. rst is synchronous; the palette is
// not cleared. in_stall rises only when both result stages are full and
// out_stall is high.
module rle_transparent_sprite_decode
  import rtsd_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [9:0]         origin_x,
  input  logic [8:0]         origin_y,
  input  logic [7:0]         sprite_width,
  input  logic [7:0]         sprite_height,
  input  logic               clip_enable,
  input  logic [7:0]         data_byte,
  input  logic [7:0]         entry_index,
  input  logic [COLOR_W-1:0] entry_color,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ADDR_W-1:0]  pixel_address,
  output logic [COLOR_W-1:0] pixel_color,
  output logic               write_pixel,
  output logic               sprite_end
);

  cfg_t               cfg;
  logic               accept, res, busy;
  pix_t               pix;
  logic [COLOR_W-1:0] pal_q;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clip_left   <= '0;
      cfg.clip_top    <= '0;
      cfg.clip_right  <= CLIP_RIGHT_RST;
      cfg.clip_bottom <= CLIP_BOTTOM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLIP_LEFT:   cfg.clip_left   <= cfg_data;
        CFG_CLIP_TOP:    cfg.clip_top    <= cfg_data[7:0];
        CFG_CLIP_RIGHT:  cfg.clip_right  <= cfg_data;
        CFG_CLIP_BOTTOM: cfg.clip_bottom <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  rtsd_walker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_walker (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .kind         (kind),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .sprite_width (sprite_width),
    .sprite_height(sprite_height),
    .clip_enable  (clip_enable),
    .data_byte    (data_byte),
    .cfg          (cfg),
    .res          (res),
    .pix          (pix)
  );

  rtsd_palette u_palette (
    .clk  (clk),
    .we   (accept && (kind == KIND_PALETTE)),
    .waddr(entry_index),
    .wdata(entry_color),
    .re   (res),
    .raddr(data_byte),
    .rdata(pal_q)
  );

  rtsd_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (res),
    .pix          (pix),
    .pal_q        (pal_q),
    .out_stall    (out_stall),
    .busy         (busy),
    .out_valid    (out_valid),
    .pixel_address(pixel_address),
    .pixel_color  (pixel_color),
    .write_pixel  (write_pixel),
    .sprite_end   (sprite_end)
  );

endmodule

/* hdl/rtsd_palette.sv */
// 256 x 16 palette memory, one write port and one registered read port.
// Uses rtsd_pkg.
module rtsd_palette
  import rtsd_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [7:0]         waddr,
  input  logic [COLOR_W-1:0] wdata,
  input  logic               re,
  input  logic [7:0]         raddr,
  output logic [COLOR_W-1:0] rdata
);

  logic [COLOR_W-1:0] mem [256];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/rtsd_walker.sv */
// Run bookkeeping for the sprite stream: row/column tracking, clip test and
// screen address. Uses rtsd_pkg.
module rtsd_walker
  import rtsd_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [1:0] kind,
  input  logic [9:0] origin_x,
  input  logic [8:0] origin_y,
  input  logic [7:0] sprite_width,
  input  logic [7:0] sprite_height,
  input  logic       clip_enable,
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  output logic       res,
  output pix_t       pix
);

  logic       active, active_next;
  logic [9:0] base_x, base_x_next;
  logic [8:0] base_y, base_y_next;
  logic [7:0] width_reg, width_reg_next;
  logic [7:0] height_reg, height_reg_next;
  logic       clip_flag, clip_flag_next;
  logic [7:0] row_index, row_index_next;
  logic [8:0] column_index, column_index_next;
  logic [9:0] width_left, width_left_next;
  logic       opaque, opaque_next;
  logic [7:0] pixels_left, pixels_left_next;

  logic signed [POS_W-1:0] col_s, row_s;
  logic                    on_screen, in_clip, vis;
  logic [9:0]              wl_sub;
  logic                    row_end;
  logic [ADDR_W-1:0]       addr;

  assign col_s = $signed({{2{base_x[9]}}, base_x}) + $signed({3'b000, column_index});
  assign row_s = $signed({{3{base_y[8]}}, base_y}) + $signed({4'b0000, row_index});

  assign on_screen = !col_s[POS_W-1] && (col_s < $signed(POS_W'(SCREEN_WIDTH))) &&
                     !row_s[POS_W-1] && (row_s < $signed(POS_W'(SCREEN_HEIGHT)));
  assign in_clip = (column_index < {1'b0, width_reg}) &&
                   (col_s >= $signed({3'b000, cfg.clip_left})) &&
                   (col_s <  $signed({3'b000, cfg.clip_right})) &&
                   (row_s >= $signed({4'b0000, cfg.clip_top})) &&
                   (row_s <  $signed({4'b0000, cfg.clip_bottom}));

  assign addr = ADDR_W'(row_s[9:0]) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col_s[9:0]);
  assign wl_sub = width_left - {2'b00, data_byte};

  always_comb begin
    active_next       = active;
    base_x_next       = base_x;
    base_y_next       = base_y;
    width_reg_next    = width_reg;
    height_reg_next   = height_reg;
    clip_flag_next    = clip_flag;
    row_index_next    = row_index;
    column_index_next = column_index;
    width_left_next   = width_left;
    opaque_next       = opaque;
    pixels_left_next  = pixels_left;
    res               = 1'b0;
    vis               = 1'b0;
    row_end           = 1'b0;
    pix               = '0;

    if (accept) begin
      case (kind)
        KIND_START: begin
          base_x_next       = origin_x;
          base_y_next       = origin_y;
          width_reg_next    = sprite_width;
          height_reg_next   = sprite_height;
          clip_flag_next    = clip_enable;
          row_index_next    = '0;
          column_index_next = '0;
          width_left_next   = {2'b00, sprite_width};
          opaque_next       = 1'b0;
          pixels_left_next  = '0;
          active_next       = (sprite_width != '0) && (sprite_height != '0);
        end
        KIND_DATA: begin
          if (active) begin
            res = 1'b1;
            if (opaque && pixels_left != '0) begin
              vis               = on_screen && (!clip_flag || in_clip);
              column_index_next = column_index + 9'd1;
              pixels_left_next  = pixels_left - 8'd1;
              if (pixels_left == 8'd1) begin
                opaque_next = 1'b0;
                row_end     = width_left[9] || (width_left == '0);
              end
            end else if (!opaque) begin
              column_index_next = column_index + {1'b0, data_byte};
              width_left_next   = wl_sub;
              opaque_next       = 1'b1;
              row_end           = wl_sub[9] || (wl_sub == '0);
            end else begin
              width_left_next  = wl_sub;
              pixels_left_next = data_byte;
              if (data_byte == '0) begin
                opaque_next = 1'b0;
                row_end     = wl_sub[9] || (wl_sub == '0);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (row_end) begin
      row_index_next    = row_index + 8'd1;
      column_index_next = '0;
      width_left_next   = {2'b00, width_reg};
      opaque_next       = 1'b0;
      pixels_left_next  = '0;
      if (({1'b0, row_index} + 9'd1) >= {1'b0, height_reg}) begin
        active_next = 1'b0;
        pix.done    = 1'b1;
      end
    end

    pix.wr   = vis;
    pix.addr = vis ? addr : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      base_x       <= '0;
      base_y       <= '0;
      width_reg    <= '0;
      height_reg   <= '0;
      clip_flag    <= 1'b0;
      row_index    <= '0;
      column_index <= '0;
      width_left   <= '0;
      opaque       <= 1'b0;
      pixels_left  <= '0;
    end else begin
      active       <= active_next;
      base_x       <= base_x_next;
      base_y       <= base_y_next;
      width_reg    <= width_reg_next;
      height_reg   <= height_reg_next;
      clip_flag    <= clip_flag_next;
      row_index    <= row_index_next;
      column_index <= column_index_next;
      width_left   <= width_left_next;
      opaque       <= opaque_next;
      pixels_left  <= pixels_left_next;
    end
  end

endmodule

/* hdl/rtsd_out.sv */
// Result pipeline: stage register alongside the palette read, then the
// output register that holds a beat under stall. Uses rtsd_pkg.
module rtsd_out
  import rtsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  pix_t               pix,
  input  logic [COLOR_W-1:0] pal_q,
  input  logic               out_stall,
  output logic               busy,
  output logic               out_valid,
  output logic [ADDR_W-1:0]  pixel_address,
  output logic [COLOR_W-1:0] pixel_color,
  output logic               write_pixel,
  output logic               sprite_end
);

  logic a_valid;
  pix_t a_pix;
  logic b_free, a_move;

  assign b_free = !out_valid || !out_stall;
  assign a_move = a_valid && b_free;
  assign busy   = a_valid && !b_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (load) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_pix <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_free) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      pixel_address <= a_pix.addr;
      pixel_color   <= a_pix.wr ? pal_q : '0;
      write_pixel   <= a_pix.wr;
      sprite_end    <= a_pix.done;
    end
  end

endmodule

/* sim/sprite_check_pkg.sv */
`timescale 1ns / 1ps
// Beat and pixel types plus a scoreboard class that predicts the result of
// every accepted data beat of an active sprite and checks what the decoder
// reports. Depends on rtsd_pkg.
package sprite_check_pkg;
  import rtsd_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SCR_W = DEF_SCREEN_WIDTH;
  localparam int SCR_H = DEF_SCREEN_HEIGHT;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         origin_x;
    logic [8:0]         origin_y;
    logic [7:0]         sprite_width;
    logic [7:0]         sprite_height;
    logic               clip_enable;
    logic [7:0]         data_byte;
    logic [7:0]         entry_index;
    logic [COLOR_W-1:0] entry_color;
  } sprite_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               wr;
    logic               done;
  } pixel_result_t;

  class sprite_pixel_checker;
    int clip_left, clip_top, clip_right, clip_bottom;
    bit [15:0] palette [256];
    bit inked [256];
    bit active, clipped, opaque;
    int base_x, base_y, width, height;
    int row, col, width_left, pixels_left;
    pixel_result_t expected_pixels [$];
    int errors;

    function new();
      clip_left   = 0;
      clip_top    = 0;
      clip_right  = CLIP_RIGHT_RST;
      clip_bottom = CLIP_BOTTOM_RST;
    endfunction

    function void set_clip(cfg_idx_t idx, int value);
      case (idx)
        CFG_CLIP_LEFT:   clip_left = value;
        CFG_CLIP_TOP:    clip_top = value;
        CFG_CLIP_RIGHT:  clip_right = value;
        CFG_CLIP_BOTTOM: clip_bottom = value;
      endcase
    endfunction

    function bit next_row();
      row++;
      col = 0;
      width_left = width;
      opaque = 0;
      pixels_left = 0;
      if (row >= height) begin
        active = 0;
        return 1;
      end
      return 0;
    endfunction

    // Advances the decoder state by one beat; returns 1 when a result is due.
    function bit decode(sprite_beat_t b, output pixel_result_t px);
      int c, r;
      bit vis;
      px = '0;
      case (b.kind)
        KIND_START: begin
          base_x = $signed(b.origin_x);
          base_y = $signed(b.origin_y);
          width = b.sprite_width;
          height = b.sprite_height;
          clipped = b.clip_enable;
          row = 0;
          col = 0;
          width_left = width;
          opaque = 0;
          pixels_left = 0;
          active = (width != 0 && height != 0);
          return 0;
        end
        KIND_PALETTE: begin
          palette[b.entry_index] = b.entry_color;
          inked[b.entry_index] = 1;
          return 0;
        end
        KIND_DATA: ;
        default: return 0;
      endcase
      if (!active) return 0;
      if (opaque && pixels_left > 0) begin
        c = base_x + col;
        r = base_y + row;
        vis = c >= 0 && c < SCR_W && r >= 0 && r < SCR_H;
        if (clipped)
          vis = vis && col < width && c >= clip_left && c < clip_right &&
                r >= clip_top && r < clip_bottom;
        if (vis) begin
          px.wr = 1;
          px.addr = ADDR_W'(r * SCR_W + c);
          px.color = palette[b.data_byte];
        end
        col = (col + 1) & 'h1ff;
        pixels_left--;
        if (pixels_left == 0) begin
          opaque = 0;
          if (width_left <= 0) px.done = next_row();
        end
      end else if (!opaque) begin
        col = (col + int'(b.data_byte)) & 'h1ff;
        width_left -= int'(b.data_byte);
        opaque = 1;
        if (width_left <= 0) px.done = next_row();
      end else begin
        width_left -= int'(b.data_byte);
        pixels_left = b.data_byte;
        if (b.data_byte == 0) begin
          opaque = 0;
          if (width_left <= 0) px.done = next_row();
        end
      end
      return 1;
    endfunction

    function void note_beat(sprite_beat_t b);
      pixel_result_t px;
      if (decode(b, px)) expected_pixels.push_back(px);
    endfunction

    function void check_pixel(logic [ADDR_W-1:0] addr, logic [COLOR_W-1:0] color,
                              logic wr, logic done);
      pixel_result_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: pixel_address %0d pixel_color %h", addr, color);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (addr !== want.addr) begin
        $error("pixel_address expected %0d got %0d", want.addr, addr);
        errors++;
      end
      if (color !== want.color) begin
        $error("pixel_color expected %h got %h", want.color, color);
        errors++;
      end
      if (wr !== want.wr) begin
        $error("write_pixel expected %0b got %0b", want.wr, wr);
        errors++;
      end
      if (done !== want.done) begin
        $error("sprite_end expected %0b got %0b", want.done, done);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void report_leftover();
      if (expected_pixels.size() != 0) begin
        $error("%0d expected results never arrived", expected_pixels.size());
        errors += expected_pixels.size();
      end
    endfunction
  endclass

endpackage

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Testbench for rle_transparent_sprite_decode: random run-length sprites,
// palette writes and clip settings with random gaps and stalls on both sides.
// Depends on rtsd_pkg, sprite_check_pkg and the decoder RTL.
module testbench;
  import rtsd_pkg::*;
  import sprite_check_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int BEATS_PER_PHASE = 315;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         kind = '0;
  logic [9:0]         origin_x = '0;
  logic [8:0]         origin_y = '0;
  logic [7:0]         sprite_width = '0;
  logic [7:0]         sprite_height = '0;
  logic               clip_enable = 1'b0;
  logic [7:0]         data_byte = '0;
  logic [7:0]         entry_index = '0;
  logic [COLOR_W-1:0] entry_color = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ADDR_W-1:0]  pixel_address;
  logic [COLOR_W-1:0] pixel_color;
  logic               write_pixel;
  logic               sprite_end;

  sprite_pixel_checker sb;
  sprite_pixel_checker plan;
  logic [7:0] inks [$];
  bit idle_on = 1'b1;
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;
  int stall_left = 0;
  int stuck_cycles = 0;

  rle_transparent_sprite_decode DUT (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idle_on && !recv_quiet && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 16);
    if ($urandom_range(0, 59) == 0) recv_quiet = !recv_quiet;
    out_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0)
      sb.check_pixel(pixel_address, pixel_color, write_pixel, sprite_end);
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic sprite_beat_t noise_beat();
    sprite_beat_t it;
    it.kind = 2'($urandom);
    it.origin_x = 10'($urandom);
    it.origin_y = 9'($urandom);
    it.sprite_width = 8'($urandom);
    it.sprite_height = 8'($urandom);
    it.clip_enable = 1'($urandom);
    it.data_byte = 8'($urandom);
    it.entry_index = 8'($urandom);
    it.entry_color = 16'($urandom);
    return it;
  endfunction

  function automatic sprite_beat_t start_beat(int ox, int oy, int w, int h, bit clip);
    sprite_beat_t it;
    it = noise_beat();
    it.kind = KIND_START;
    it.origin_x = 10'(ox);
    it.origin_y = 9'(oy);
    it.sprite_width = 8'(w);
    it.sprite_height = 8'(h);
    it.clip_enable = clip;
    return it;
  endfunction

  function automatic sprite_beat_t data_beat(int value);
    sprite_beat_t it;
    it = noise_beat();
    it.kind = KIND_DATA;
    it.data_byte = 8'(value);
    return it;
  endfunction

  function automatic sprite_beat_t palette_beat(int idx, int color);
    sprite_beat_t it;
    it = noise_beat();
    it.kind = KIND_PALETTE;
    it.entry_index = 8'(idx);
    it.entry_color = 16'(color);
    return it;
  endfunction

  // Mostly well-formed rows with random content; pixel indices only ever
  // name palette entries that have been written.
  function automatic sprite_beat_t make_item();
    sprite_beat_t it;
    int pick, r2, wl, n, w, h, ox, oy;
    pick = $urandom_range(0, 99);
    r2 = $urandom_range(0, 99);
    wl = plan.width_left;
    if ((!plan.active && pick < 70) || (plan.active && pick < 2)) begin
      ox = (r2 < 80) ? $urandom_range(0, 370) - 40 : $urandom_range(0, 1023) - 512;
      oy = (r2 < 80) ? $urandom_range(0, 290) - 30 : $urandom_range(0, 511) - 256;
      n = $urandom_range(0, 99);
      if (n < 3) w = 0;
      else if (n < 6) w = 255;
      else if (n < 9) w = $urandom_range(25, 254);
      else w = $urandom_range(1, 24);
      n = $urandom_range(0, 99);
      if (n < 3) h = 0;
      else if (n < 5) h = $urandom_range(200, 255);
      else h = $urandom_range(1, 5);
      it = start_beat(ox, oy, w, h, 1'($urandom));
    end else if ((!plan.active && pick < 88) || (plan.active && pick < 5)) begin
      it = palette_beat($urandom_range(0, 255), $urandom_range(0, 65535));
    end else if ((!plan.active && pick < 97) || (plan.active && pick >= 6)) begin
      if (!plan.active) begin
        n = $urandom_range(0, 255);
      end else if (plan.opaque && plan.pixels_left > 0) begin
        n = inks[$urandom_range(0, inks.size() - 1)];
      end else if (!plan.opaque) begin
        if (plan.height > 24 && (plan.width > 24 || r2 < 92)) n = wl;
        else if (r2 < 10) n = 0;
        else if (r2 < 22) n = wl;
        else if (r2 < 27) n = $urandom_range(wl, 255);
        else n = $urandom_range(0, wl);
      end else begin
        if (r2 < 10) n = 0;
        else if (r2 < 25) n = wl;
        else if (r2 < 33) begin
          n = wl + $urandom_range(1, 4);
          if (n > 255) n = 255;
        end else n = $urandom_range(1, wl);
      end
      it = data_beat(n);
    end else begin
      it = noise_beat();
      it.kind = KIND_UNUSED;
    end
    return it;
  endfunction

  task automatic issue(sprite_beat_t it);
    pixel_result_t scratch;
    if (it.kind == KIND_PALETTE && !plan.inked[it.entry_index])
      inks.push_back(it.entry_index);
    void'(plan.decode(it, scratch));
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    if (idle_on && !send_quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    kind <= it.kind;
    origin_x <= it.origin_x;
    origin_y <= it.origin_y;
    sprite_width <= it.sprite_width;
    sprite_height <= it.sprite_height;
    clip_enable <= it.clip_enable;
    data_byte <= it.data_byte;
    entry_index <= it.entry_index;
    entry_color <= it.entry_color;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_beat(it);
  endtask

  task automatic write_clip(cfg_idx_t idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    sb.set_clip(idx, value);
    plan.set_clip(idx, value);
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_directed();
    int row_a [8] = '{0, 5, 255, 0, 90, 255, 0, 255};
    int row_b [6] = '{0, 4, 90, 255, 0, 90};
    sprite_beat_t it;
    issue(palette_beat(8'h00, 16'h0000));
    issue(palette_beat(8'hff, 16'hffff));
    issue(palette_beat(8'h5a, 16'ha5a5));
    issue(data_beat(8'hff));
    it = noise_beat();
    it.kind = KIND_UNUSED;
    issue(it);
    issue(start_beat(10, 10, 0, 3, 1'b0));
    issue(start_beat(10, 10, 4, 0, 1'b1));
    // tallest and widest sprite, abandoned by the next start
    issue(start_beat(-512, -256, 255, 255, 1'b1));
    issue(data_beat(3));
    // unclipped overrun at the bottom-right corner, last row fully transparent
    issue(start_beat(316, 239, 4, 2, 1'b0));
    foreach (row_a[i]) issue(data_beat(row_a[i]));
    // clipped overrun hanging off the left edge
    issue(start_beat(-2, 0, 3, 1, 1'b1));
    foreach (row_b[i]) issue(data_beat(row_b[i]));
  endtask

  initial begin
    sprite_beat_t it;
    int n;
    sb = new();
    plan = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: begin
            write_clip(CFG_CLIP_LEFT, 0);
            write_clip(CFG_CLIP_TOP, 0);
            write_clip(CFG_CLIP_RIGHT, 320);
            write_clip(CFG_CLIP_BOTTOM, 240);
          end
          2: begin
            write_clip(CFG_CLIP_LEFT, 320);
            write_clip(CFG_CLIP_TOP, 240);
            write_clip(CFG_CLIP_RIGHT, 0);
            write_clip(CFG_CLIP_BOTTOM, 0);
          end
          3: begin
            write_clip(CFG_CLIP_LEFT, $urandom_range(0, 160));
            write_clip(CFG_CLIP_TOP, $urandom_range(0, 120));
            write_clip(CFG_CLIP_RIGHT, $urandom_range(160, 320));
            write_clip(CFG_CLIP_BOTTOM, $urandom_range(120, 240));
          end
          4: begin
            write_clip(CFG_CLIP_LEFT, $urandom_range(0, 320));
            write_clip(CFG_CLIP_TOP, $urandom_range(0, 240));
            write_clip(CFG_CLIP_RIGHT, $urandom_range(0, 320));
            write_clip(CFG_CLIP_BOTTOM, $urandom_range(0, 240));
          end
          default: begin
            write_clip(CFG_CLIP_LEFT, $urandom_range(0, 40));
            write_clip(CFG_CLIP_TOP, $urandom_range(0, 40));
            write_clip(CFG_CLIP_RIGHT, $urandom_range(280, 320));
            write_clip(CFG_CLIP_BOTTOM, $urandom_range(200, 240));
          end
        endcase
        cfg_we <= 1'b0;
      end
      idle_on = (p < 5);
      if (p == 0) run_directed();
      n = 0;
      while (n < BEATS_PER_PHASE) begin
        it = make_item();
        if (!(it.kind == KIND_UNUSED || (it.kind == KIND_DATA && !plan.active))) n++;
        issue(it);
      end
      in_valid <= 1'b0;
    end
    settle();
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
